// ----- rtl/lmst_pkg.sv -----
// Shared types, constants and mask helpers for the LED matrix slide transition.
// Used by the row cells, the output cells and the top level; no dependencies.
package lmst_pkg;

    localparam int unsigned NUM_ROWS  = 10;
    localparam int unsigned ROW_W     = 16;
    localparam int unsigned ROW_IDX_W = 4;
    localparam int unsigned CNT_W     = 6;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [1:0] PHASE_OUT  = 2'd0;
    localparam logic [1:0] PHASE_IN   = 2'd1;
    localparam logic [1:0] PHASE_DONE = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX        = 6'd63;
    localparam logic [CNT_W-1:0] RISE_START       = 6'd22;
    localparam logic [CNT_W-1:0] PHASE_IN_AFTER   = 6'd20;
    localparam logic [CNT_W-1:0] PHASE_DONE_AFTER = 6'd41;
    localparam logic [CNT_W-1:0] MAX_COLS         = 6'd12;

    // step index plus count, offset so that the rising column is sum - RISE_COL_BASE
    localparam logic [6:0] RISE_COL_BASE = 7'd31;
    localparam logic [6:0] RISE_COL_LAST = 7'd42;

    typedef struct packed {
        logic             load_shf;
        logic             shift;
        logic             upd;
        logic             slide;
        logic [ROW_W-1:0] mask;
    } cell_ctl_t;

    function automatic logic [ROW_W-1:0] col_mask(input logic [3:0] col);
        return 16'h8000 >> col;
    endfunction

    function automatic logic [ROW_W-1:0] lead_mask(input logic [3:0] ncols);
        return ~(16'hFFFF >> ncols);
    endfunction

endpackage

// ----- rtl/lmst_row_cell.sv -----
// One display row: shown row, target row and a working copy of the target row
// that shifts down the chain during a step. Depends on lmst_pkg.
module lmst_row_cell import lmst_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load_en,
    input  logic [ROW_W-1:0] old_row,
    input  logic [ROW_W-1:0] new_row,
    input  cell_ctl_t        ctl,
    input  logic [ROW_W-1:0] above_shown,
    input  logic [ROW_W-1:0] above_shf,
    output logic [ROW_W-1:0] shown_q,
    output logic [ROW_W-1:0] shown_nx,
    output logic [ROW_W-1:0] shf_q
);

    logic [ROW_W-1:0] shown_reg;
    logic [ROW_W-1:0] target_reg;
    logic [ROW_W-1:0] shf_reg;
    logic [ROW_W-1:0] shown_next;
    logic [ROW_W-1:0] src;

    assign src = ctl.slide ? above_shown : shf_reg;

    always_comb begin
        shown_next = shown_reg;
        if (load_en) begin
            shown_next = old_row;
        end else if (ctl.upd) begin
            shown_next = (shown_reg & ~ctl.mask) | (src & ctl.mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg  <= '0;
            target_reg <= '0;
        end else begin
            shown_reg <= shown_next;
            if (load_en) begin
                target_reg <= new_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_shf) begin
            shf_reg <= target_reg;
        end else if (ctl.shift) begin
            shf_reg <= above_shf;
        end
    end

    assign shown_q  = shown_reg;
    assign shown_nx = shown_next;
    assign shf_q    = shf_reg;

endmodule

// ----- rtl/lmst_tx_cell.sv -----
// One stage of the output row buffer: loads a finished row, then shifts toward
// the output port on each accepted result. Depends on lmst_pkg.
module lmst_tx_cell import lmst_pkg::*; (
    input  logic             aclk,
    input  logic             load,
    input  logic             shift,
    input  logic [ROW_W-1:0] load_val,
    input  logic [ROW_W-1:0] next_val,
    output logic [ROW_W-1:0] q
);

    logic [ROW_W-1:0] row_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= load_val;
        end else if (shift) begin
            row_reg <= next_val;
        end
    end

    assign q = row_reg;

endmodule

// ----- rtl/led_matrix_slide_transition.sv -----
// Top level of the LED matrix slide transition: step control, row cell chain
// and output row buffer. Depends on lmst_pkg, lmst_row_cell and lmst_tx_cell.
//
// Input requests arrive on s_tvalid/s_tready with the command in s_tuser.
// A load request writes one row of the outgoing and incoming frames and
// produces no result. A start or step request advances the step count and
// runs an update pass through the chain of ten row cells, one position of
// the shifting incoming frame at a time; the input accepts again once the
// pass is over and the finished frame has been handed to the output buffer.
// The finished frame is copied into a ten-stage output buffer and leaves as
// ten results on m_tvalid/m_tready, rows 0 to 9, m_tlast on row 9. The next
// step request can be taken and computed while the buffer drains.
// If the receiver stalls, the buffer holds; a finished step waits until the
// buffer has been emptied, and the input stays closed until then.
// Reset (aresetn low, synchronous) clears both frames, the step count and
// all pending results.
module led_matrix_slide_transition import lmst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_select[3:0], old_row[19:4], new_row[35:20]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // row_number[3:0], row_pixels[19:4], phase[21:20]
    output logic        m_tlast
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

    state_t                 state_reg;
    logic [3:0]             pos_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [1:0]             phase_reg;
    logic [3:0]             out_cnt_reg;

    logic [1:0]             in_cmd;
    logic [ROW_IDX_W-1:0]   in_row;
    logic [ROW_W-1:0]       in_old;
    logic [ROW_W-1:0]       in_new;
    logic                   s_accept;
    logic                   is_step;
    logic [CNT_W-1:0]       count_base;
    logic [CNT_W-1:0]       count_next;
    logic                   out_pop;
    logic                   out_free;
    logic                   run_last;
    logic                   handoff;
    logic [6:0]             rise_sum;
    logic                   rise_ok;
    logic [3:0]             rise_col;
    logic [3:0]             slide_cols;
    logic                   in_slide;
    logic [1:0]             phase_now;
    logic [ROW_IDX_W-1:0]   row_number;
    cell_ctl_t              ctl;

    logic [ROW_W-1:0]       shown_q    [NUM_ROWS];
    logic [ROW_W-1:0]       shown_nx   [NUM_ROWS];
    logic [ROW_W-1:0]       shf_q      [NUM_ROWS];
    logic [ROW_W-1:0]       above_shown[NUM_ROWS];
    logic [ROW_W-1:0]       above_shf  [NUM_ROWS];
    logic [ROW_W-1:0]       tx_q       [NUM_ROWS];
    logic [ROW_W-1:0]       tx_next    [NUM_ROWS];

    assign in_cmd = s_tuser;
    assign in_row = s_tdata[3:0];
    assign in_old = s_tdata[19:4];
    assign in_new = s_tdata[35:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_step  = s_accept && (in_cmd == CMD_START || in_cmd == CMD_STEP);

    assign count_base = (in_cmd == CMD_START) ? '0 : count_reg;
    assign count_next = (count_base == COUNT_MAX) ? count_base : count_base + 6'd1;

    assign out_pop  = m_tvalid && m_tready;
    assign out_free = (out_cnt_reg == 4'd0) || (out_cnt_reg == 4'd1 && m_tready);
    assign run_last = (state_reg == ST_RUN) && (pos_reg == 4'(NUM_ROWS - 1));
    assign handoff  = (run_last || state_reg == ST_HOLD) && out_free;

    // rising column for this cycle of the step
    assign rise_sum   = {3'd0, pos_reg} + {1'b0, count_reg};
    assign rise_ok    = (count_reg >= RISE_START) && (rise_sum >= RISE_COL_BASE)
                        && (rise_sum <= RISE_COL_LAST);
    assign rise_col   = 4'(rise_sum - RISE_COL_BASE);
    assign in_slide   = (count_reg < RISE_START);
    assign slide_cols = (count_reg < MAX_COLS) ? count_reg[3:0] : MAX_COLS[3:0];

    always_comb begin
        ctl.load_shf = is_step;
        ctl.shift    = (state_reg == ST_RUN);
        ctl.slide    = in_slide;
        ctl.upd      = (state_reg == ST_RUN)
                       && (in_slide ? (pos_reg == 4'd0) : rise_ok);
        ctl.mask     = in_slide ? lead_mask(slide_cols) : col_mask(rise_col);
    end

    always_comb begin
        if (count_reg > PHASE_DONE_AFTER) begin
            phase_now = PHASE_DONE;
        end else if (count_reg > PHASE_IN_AFTER) begin
            phase_now = PHASE_IN;
        end else begin
            phase_now = PHASE_OUT;
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_rows
        if (r == 0) begin : g_top
            assign above_shown[r] = '0;
            assign above_shf[r]   = '0;
        end else begin : g_inner
            assign above_shown[r] = shown_q[r-1];
            assign above_shf[r]   = shf_q[r-1];
        end

        if (r == NUM_ROWS - 1) begin : g_tx_end
            assign tx_next[r] = '0;
        end else begin : g_tx_mid
            assign tx_next[r] = tx_q[r+1];
        end

        lmst_row_cell u_row (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .load_en     (s_accept && in_cmd == CMD_LOAD && in_row == ROW_IDX_W'(r)),
            .old_row     (in_old),
            .new_row     (in_new),
            .ctl         (ctl),
            .above_shown (above_shown[r]),
            .above_shf   (above_shf[r]),
            .shown_q     (shown_q[r]),
            .shown_nx    (shown_nx[r]),
            .shf_q       (shf_q[r])
        );

        lmst_tx_cell u_tx (
            .aclk     (aclk),
            .load     (handoff),
            .shift    (out_pop),
            .load_val (shown_nx[r]),
            .next_val (tx_next[r]),
            .q        (tx_q[r])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            count_reg   <= '0;
            phase_reg   <= PHASE_OUT;
            out_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (is_step) begin
                        count_reg <= count_next;
                        pos_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    pos_reg <= pos_reg + 4'd1;
                    if (run_last) begin
                        state_reg <= handoff ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (handoff) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (handoff) begin
                out_cnt_reg <= 4'(NUM_ROWS);
                phase_reg   <= phase_now;
            end else if (out_pop) begin
                out_cnt_reg <= out_cnt_reg - 4'd1;
            end
        end
    end

    assign row_number = 4'(NUM_ROWS) - out_cnt_reg;
    assign m_tvalid   = (out_cnt_reg != 4'd0);
    assign m_tlast    = (out_cnt_reg == 4'd1);
    assign m_tdata    = {2'd0, phase_reg, tx_q[0], row_number};

    a_out_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= 4'(NUM_ROWS))
        else $error("output row count out of range");

    a_step_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        is_step |=> (state_reg == ST_RUN && pos_reg == 4'd0 && count_reg != '0))
        else $error("step did not start an update run");

    a_burst_starts_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[3:0] == 4'd0))
        else $error("result burst does not start at row zero");

    a_handoff_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        handoff |=> (out_cnt_reg == 4'(NUM_ROWS) && state_reg == ST_IDLE))
        else $error("frame handoff left control inconsistent");

endmodule

// ----- tb/tb.sv -----
// Testbench for led_matrix_slide_transition: drives load, start, step and unused requests
// and checks every displayed row against a frame predictor kept in the bench.
// Depends on lmst_pkg and the led_matrix_slide_transition RTL.
module tb;
    import lmst_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 30;
    localparam int MAX_PRINTS = 100;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BURSTS} ready_mode_t;

    typedef struct {
        logic [3:0]  row_number;
        logic [15:0] row_pixels;
        logic [1:0]  phase;
        logic        last;
    } display_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // row_select[3:0], old_row[19:4], new_row[35:20]
    logic [1:0]  s_tuser = '0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // row_number[3:0], row_pixels[19:4], phase[21:20]
    logic        m_tlast;

    logic [15:0] shown_rows [NUM_ROWS];
    logic [15:0] target_rows [NUM_ROWS];
    logic [5:0]  step_count;
    display_row_t expected_rows [$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          random_items = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    ready_mode_t ready_mode = READY_ALWAYS;
    bit          ready_level = 1'b1;
    int          ready_run = 0;

    led_matrix_slide_transition u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic logic [15:0] column_bit(input int col);
        return 16'h8000 >> col;
    endfunction

    function automatic void advance_frame();
        int          lo;
        int          hi;
        int          cnt;
        int          offset;
        int          src;
        logic [15:0] m;
        logic [15:0] v;
        logic [1:0]  ph;
        display_row_t item;
        if (step_count != COUNT_MAX) step_count = step_count + 6'd1;
        cnt = int'(step_count);
        if (cnt < int'(RISE_START)) begin
            hi = (cnt < int'(MAX_COLS)) ? cnt : int'(MAX_COLS);
            for (int c = 0; c < hi; c++) begin
                m = column_bit(c);
                for (int r = NUM_ROWS - 1; r > 0; r--) begin
                    shown_rows[r] = (shown_rows[r] & ~m) | (shown_rows[r-1] & m);
                end
                shown_rows[0] = shown_rows[0] & ~m;
            end
        end else begin
            lo = cnt - int'(RISE_START) - 9;
            if (lo < 0) lo = 0;
            hi = cnt - (int'(RISE_START) - 1);
            if (hi > int'(MAX_COLS)) hi = int'(MAX_COLS);
            for (int c = lo; c < hi; c++) begin
                m = column_bit(c);
                offset = 9 + c - (cnt - int'(RISE_START));
                for (int r = 0; r < NUM_ROWS; r++) begin
                    src = r - offset;
                    v = shown_rows[r] & ~m;
                    if (src >= 0 && src < NUM_ROWS) v = v | (target_rows[src] & m);
                    shown_rows[r] = v;
                end
            end
        end
        ph = PHASE_OUT;
        if (step_count > PHASE_IN_AFTER) ph = PHASE_IN;
        if (step_count > PHASE_DONE_AFTER) ph = PHASE_DONE;
        for (int r = 0; r < NUM_ROWS; r++) begin
            item.row_number = 4'(r);
            item.row_pixels = shown_rows[r];
            item.phase = ph;
            item.last = (r == NUM_ROWS - 1);
            expected_rows.push_back(item);
        end
    endfunction

    function automatic void predict_request(input logic [1:0] cmd, input logic [3:0] row,
                                            input logic [15:0] old_bits,
                                            input logic [15:0] new_bits);
        case (cmd)
            CMD_LOAD: begin
                if (row < NUM_ROWS) begin
                    shown_rows[row] = old_bits;
                    target_rows[row] = new_bits;
                end
            end
            CMD_START: begin
                step_count = '0;
                advance_frame();
            end
            CMD_STEP: begin
                advance_frame();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string text);
        if (error_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, text);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (ready_mode == READY_ALWAYS) begin
            m_tready <= 1'b1;
        end else if (ready_mode == READY_RANDOM) begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            if (ready_run == 0) begin
                ready_level = ~ready_level;
                ready_run = ready_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end else begin
                ready_run--;
            end
            m_tready <= ready_level;
        end
    end

    always @(posedge aclk) begin
        display_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row, tdata %h", m_tdata));
            end else begin
                want = expected_rows.pop_front();
                if (m_tdata[3:0] !== want.row_number)
                    report_mismatch($sformatf("row_number %0d, want %0d",
                                              m_tdata[3:0], want.row_number));
                if (m_tdata[19:4] !== want.row_pixels)
                    report_mismatch($sformatf("row %0d pixels %h, want %h",
                                              want.row_number, m_tdata[19:4], want.row_pixels));
                if (m_tdata[21:20] !== want.phase)
                    report_mismatch($sformatf("row %0d phase %0d, want %0d",
                                              want.row_number, m_tdata[21:20], want.phase));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("row %0d tlast %b, want %b",
                                              want.row_number, m_tlast, want.last));
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [3:0] row,
                                input logic [15:0] old_bits, input logic [15:0] new_bits);
        int gap;
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, new_bits, old_bits, row};
        do @(posedge aclk); while (!s_tready);
        predict_request(cmd, row, old_bits, new_bits);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_random(input logic [1:0] cmd, input logic [3:0] row,
                               input logic [15:0] old_bits, input logic [15:0] new_bits);
        send_request(cmd, row, old_bits, new_bits);
        if (cmd != CMD_UNUSED && !(cmd == CMD_LOAD && row >= NUM_ROWS)) random_items++;
    endtask

    function automatic logic [15:0] random_row();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return column_bit($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_load_edges();
        gaps_on = 1'b0;
        ready_mode = READY_ALWAYS;
        send_request(CMD_LOAD, 4'd0, 16'hFFFF, 16'h0000);
        send_request(CMD_LOAD, 4'd9, 16'h0000, 16'hFFFF);
        send_request(CMD_LOAD, 4'd4, 16'hA5A5, 16'h5A5A);
        send_request(CMD_LOAD, 4'd10, 16'hFFFF, 16'hFFFF);
        send_request(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
        send_request(CMD_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_step_without_start();
        send_request(CMD_STEP, 4'd0, 16'h0000, 16'h0000);
        send_request(CMD_STEP, 4'd15, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_start_and_reload();
        ready_mode = READY_RANDOM;
        send_request(CMD_START, 4'd0, 16'h0000, 16'h0000);
        send_request(CMD_LOAD, 4'd0, 16'h1234, 16'hFEDC);
        send_request(CMD_STEP, 4'd3, 16'h0F0F, 16'hF0F0);
        send_request(CMD_START, 4'd9, 16'hFFFF, 16'h0000);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_random(CMD_LOAD, 4'($urandom_range(10, 15)), random_row(), random_row());
            1: send_random(CMD_UNUSED, 4'($urandom), random_row(), random_row());
            default: send_random(CMD_LOAD, 4'($urandom_range(0, 9)), random_row(), random_row());
        endcase
    endtask

    task automatic test_random_transitions();
        int steps;
        bit first;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            if ($urandom_range(0, 9) < 8) begin
                for (int r = 0; r < NUM_ROWS; r++)
                    send_random(CMD_LOAD, 4'(r), random_row(), random_row());
                send_random(CMD_START, 4'($urandom), random_row(), random_row());
                steps = first ? 66 : $urandom_range(1, 45);
                first = 1'b0;
                for (int i = 0; i < steps; i++) begin
                    if ($urandom_range(0, 9) == 0) send_noise();
                    send_random(CMD_STEP, 4'($urandom), random_row(), random_row());
                end
            end else begin
                for (int i = 0; i < 8; i++)
                    send_random(2'($urandom), 4'($urandom), random_row(), random_row());
            end
        end
    endtask

    initial begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            shown_rows[r] = '0;
            target_rows[r] = '0;
        end
        step_count = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_edges();
        test_step_without_start();
        test_start_and_reload();
        test_random_transitions();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
